// ===== rtl/lzssd_pkg.sv =====
package lzssd_pkg;

   // window geometry and token layout
   localparam int POS_BITS   = 11;
   localparam int LEN_BITS   = 4;
   localparam int WIN_SIZE   = 1 << POS_BITS;
   localparam int LOOKAHEAD  = (1 << LEN_BITS) + 1;
   localparam int LIT_BITS   = 8;
   localparam int MATCH_BITS = POS_BITS + LEN_BITS;
   localparam int TCNT_W     = $clog2(MATCH_BITS + 1);
   localparam int FILL_W     = POS_BITS + 1;
   localparam int REM_W      = LEN_BITS + 1;
   localparam int BCNT_W     = $clog2(LIT_BITS + 1);

   localparam logic [POS_BITS-1:0] WP_RESET = POS_BITS'(WIN_SIZE - LOOKAHEAD);
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] ZERO_CHAR  = 8'h00;

   // controller to datapath
   typedef struct packed {
      logic load;      // take a new compressed byte
      logic step;      // consume one bit of it
      logic rd;        // read the window at the copy source
      logic put_lit;   // store and emit the literal
      logic put_copy;  // store and emit the byte just read
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic lit_done;    // the bit being consumed completes a literal
      logic match_done;  // the bit being consumed completes a match
      logic step_more;   // more bits remain after the one being consumed
      logic bits_left;   // bits of the current byte still unconsumed
      logic copy_last;   // the pending copy byte is the last of the match
      logic out_free;    // output register can take a byte this cycle
   } dp_status_type;

endpackage

// ===== rtl/lzss_stream_decoder_unit.sv =====
// lzss stream decoder
//
// req_ channel carries compressed bytes, one per transaction, read msb first.
// each token is a flag bit then either an 8-bit literal (flag 1) or an 11-bit
// window position and 4-bit length j (flag 0) copying j+2 bytes from a
// 2048-byte window. rsp_ carries decoded bytes (stored byte minus one);
// rsp_tlast marks the final decoded byte caused by one input transaction.
// an input byte that completes no token gives no response.
//
// sequence: the byte is taken in ST_IDLE and its bits are walked one per
// cycle in ST_BIT, a walk that pauses while a finished literal is stored in
// ST_LIT or a finished match is copied; each copied byte is read from the
// window in ST_RD and then stored and emitted in ST_WR, and a new input byte
// is taken only once the current one is fully consumed. a literal's byte
// reaches the output register from ST_LIT, a match's bytes from ST_WR.
//
// reset restores the window contents (spaces, last 17 entries zero) by a
// fill count rather than a clearing pass, so the block is ready at once.
// a stalled rsp_ side holds the output register and stalls the next emit.
module lzss_stream_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   // compressed byte in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // decoded byte out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast    // last_in_run
);
   import lzssd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // sequencer: bit walk, literal store, read/write copy loop
   lzssd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // token assembly, window memory and output register
   lzssd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_byte   (req_tdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== rtl/lzssd_ctrl.sv =====
module lzssd_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lzssd_pkg::dp_status_type     sts,
   output lzssd_pkg::ctrl_cmd_type      cmd
);
   import lzssd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT,
      ST_LIT,
      ST_RD,
      ST_WR
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            cmd.step = 1'b1;
            if (sts.lit_done) begin
               state_in = ST_LIT;
            end else if (sts.match_done) begin
               state_in = ST_RD;
            end else if (!sts.step_more) begin
               state_in = ST_IDLE;
            end
         end
         ST_LIT: begin
            if (sts.out_free) begin
               cmd.put_lit = 1'b1;
               state_in    = sts.bits_left ? ST_BIT : ST_IDLE;
            end
         end
         ST_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            if (sts.out_free) begin
               cmd.put_copy = 1'b1;
               if (sts.copy_last) begin
                  state_in = sts.bits_left ? ST_BIT : ST_IDLE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/lzssd_datapath.sv =====
module lzssd_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  lzssd_pkg::ctrl_cmd_type      cmd,
   output lzssd_pkg::dp_status_type     sts,
   input  logic [7:0]                   in_byte,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [7:0]                   out_byte,
   output logic                         out_last
);
   import lzssd_pkg::*;

   typedef enum logic [1:0] {
      KIND_FLAG,
      KIND_LIT,
      KIND_MATCH
   } kind_type;

   // bit feed
   logic [7:0]             shift_ff, shift_in;
   logic [BCNT_W-1:0]      bcnt_ff, bcnt_in;
   // token assembly
   kind_type               kind_ff, kind_in;
   logic [MATCH_BITS-1:0]  tok_ff, tok_in;
   logic [TCNT_W-1:0]      tcnt_ff, tcnt_in;
   // copy engine
   logic [POS_BITS-1:0]    src_ff, src_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [POS_BITS-1:0]    wp_ff, wp_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   // window
   logic [7:0]             win_mem [WIN_SIZE];
   logic [7:0]             rd_data_ff;
   logic                   rd_written_ff;
   logic                   rd_high_ff;
   // output register
   logic                   oval_ff, oval_in;
   logic [7:0]             obyte_ff, obyte_in;
   logic                   olast_ff, olast_in;

   logic                   bit_cur;
   logic [MATCH_BITS-1:0]  tok_next;
   logic [TCNT_W-1:0]      tcnt_next;
   logic                   lit_done, match_done;
   logic [POS_BITS-1:0]    src_ofs;
   logic [7:0]             copy_byte;
   logic                   wr_en;
   logic [7:0]             wr_data;

   assign bit_cur    = shift_ff[7];
   assign tok_next   = {tok_ff[MATCH_BITS-2:0], bit_cur};
   assign tcnt_next  = tcnt_ff + TCNT_W'(1);
   assign lit_done   = (kind_ff == KIND_LIT)   && (tcnt_next == TCNT_W'(LIT_BITS));
   assign match_done = (kind_ff == KIND_MATCH) && (tcnt_next == TCNT_W'(MATCH_BITS));

   // unwritten entries read as their power-up contents
   assign copy_byte = rd_written_ff ? rd_data_ff : (rd_high_ff ? ZERO_CHAR : SPACE_CHAR);
   assign src_ofs   = src_ff - WP_RESET;

   assign wr_en   = cmd.put_lit || cmd.put_copy;
   assign wr_data = cmd.put_lit ? tok_ff[7:0] : copy_byte;

   always_comb begin
      sts.lit_done   = lit_done;
      sts.match_done = match_done;
      sts.step_more  = (bcnt_ff > BCNT_W'(1));
      sts.bits_left  = (bcnt_ff != '0);
      sts.copy_last  = (rem_ff == '0);
      sts.out_free   = !oval_ff || out_ready;
   end

   always_comb begin
      shift_in = shift_ff;
      bcnt_in  = bcnt_ff;
      kind_in  = kind_ff;
      tok_in   = tok_ff;
      tcnt_in  = tcnt_ff;
      src_in   = src_ff;
      rem_in   = rem_ff;
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      obyte_in = obyte_ff;
      olast_in = olast_ff;
      oval_in  = oval_ff && !out_ready;

      if (cmd.load) begin
         shift_in = in_byte;
         bcnt_in  = BCNT_W'(LIT_BITS);
      end

      if (cmd.step) begin
         shift_in = {shift_ff[6:0], 1'b0};
         bcnt_in  = bcnt_ff - BCNT_W'(1);
         if (kind_ff == KIND_FLAG) begin
            kind_in = bit_cur ? KIND_LIT : KIND_MATCH;
            tok_in  = '0;
            tcnt_in = '0;
         end else begin
            tok_in  = tok_next;
            tcnt_in = tcnt_next;
            if (lit_done || match_done) begin
               kind_in = KIND_FLAG;
            end
            if (match_done) begin
               src_in = tok_next[MATCH_BITS-1:LEN_BITS];
               rem_in = REM_W'(tok_next[LEN_BITS-1:0]) + REM_W'(1);
            end
         end
      end

      if (wr_en) begin
         wp_in    = wp_ff + POS_BITS'(1);
         fill_in  = (fill_ff == FILL_W'(WIN_SIZE)) ? fill_ff : fill_ff + FILL_W'(1);
         oval_in  = 1'b1;
         obyte_in = wr_data - 8'd1;
         olast_in = cmd.put_lit || (rem_ff == '0);
      end

      if (cmd.put_copy) begin
         src_in = src_ff + POS_BITS'(1);
         rem_in = rem_ff - REM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcnt_ff <= '0;
         kind_ff <= KIND_FLAG;
         tcnt_ff <= '0;
         rem_ff  <= '0;
         wp_ff   <= WP_RESET;
         fill_ff <= '0;
         oval_ff <= 1'b0;
      end else begin
         bcnt_ff <= bcnt_in;
         kind_ff <= kind_in;
         tcnt_ff <= tcnt_in;
         rem_ff  <= rem_in;
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         oval_ff <= oval_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      tok_ff   <= tok_in;
      src_ff   <= src_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
   end

   // window memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_mem[wp_ff] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff    <= win_mem[src_ff];
         rd_written_ff <= ({1'b0, src_ofs} < fill_ff);
         rd_high_ff    <= (src_ff >= WP_RESET);
      end
   end

   assign out_valid = oval_ff;
   assign out_byte  = obyte_ff;
   assign out_last  = olast_ff;

endmodule
